>>> rtl/sacl_pkg.sv
// shared constants, types and helpers for the set-associative cache lookup
package sacl_pkg;

  localparam int SET_COUNT  = 16;
  localparam int WAY_COUNT  = 4;
  localparam int LINE_BYTES = 16;
  localparam int ADDR_BITS  = 64;

  localparam int IN_ADDR_W   = 64;
  localparam int COUNT_W     = 32;
  localparam int OUTCOME_W   = 2;
  localparam int WAY_OUT_W   = 2;

  // floor of log2, as the offset and set fields are cut
  localparam int OFFSET_BITS = $clog2(LINE_BYTES + 1) - 1;
  localparam int SET_FIELD_W = $clog2(SET_COUNT + 1) - 1;
  localparam int SET_ROWS    = 1 << SET_FIELD_W;
  localparam int SET_IDX_W   = (SET_FIELD_W > 0) ? SET_FIELD_W : 1;
  localparam int TAG_RAW     = ADDR_BITS - SET_FIELD_W - OFFSET_BITS;
  localparam int TAG_FIELD_W = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_W       = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int CNT_W       = $clog2(WAY_COUNT + 1);

  localparam logic [IN_ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= IN_ADDR_W) ?
      {IN_ADDR_W{1'b1}} : ((IN_ADDR_W'(1) << ADDR_BITS) - IN_ADDR_W'(1));
  localparam logic [IN_ADDR_W-1:0] SET_MASK =
      (IN_ADDR_W'(1) << SET_FIELD_W) - IN_ADDR_W'(1);

  typedef logic [TAG_FIELD_W-1:0] tag_t;
  typedef logic [WAY_W-1:0]       way_t;

  // one memory row holds every way of a set
  typedef struct packed {
    tag_t [WAY_COUNT-1:0] tags;
    way_t [WAY_COUNT-1:0] ranks;
  } row_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic {
    PLC_FIFO = 1'b0,
    PLC_LRU  = 1'b1
  } policy_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } sacl_cmd_t;

  typedef struct packed {
    logic slot_busy;
  } sacl_sts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

endpackage

>>> rtl/sacl_ctrl.sv
// controller state machine: accepts an access and sequences the lookup
module sacl_ctrl import sacl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sacl_sts_t sts,
  output sacl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (!sts.slot_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RESOLVE: begin
        cmd.commit = !sts.slot_busy;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/sacl_dpath.sv
// datapath: tag memory, valid bits, way compare, rank update, counters, result register
module sacl_dpath import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sacl_cmd_t            cmd,
  output sacl_sts_t            sts,
  input  logic [IN_ADDR_W-1:0] in_address,
  input  logic                 cfg_we,
  input  logic                 cfg_replace_policy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUTCOME_W-1:0] out_outcome,
  output logic [WAY_OUT_W-1:0] out_way_used,
  output logic [COUNT_W-1:0]   out_hits_total,
  output logic [COUNT_W-1:0]   out_misses_total,
  output logic [COUNT_W-1:0]   out_evictions_total
);

  logic [IN_ADDR_W-1:0] addr_m;
  logic [IN_ADDR_W-1:0] tag_full;
  logic [SET_IDX_W-1:0] set_in;

  policy_t              policy_r;
  logic [SET_IDX_W-1:0] set_r;
  tag_t                 tag_r;
  row_t                 mem [SET_ROWS];
  row_t                 row_r;
  logic [WAY_COUNT-1:0] valid_r [SET_ROWS];
  logic [WAY_COUNT-1:0] vrow_r;

  row_t                 row_nxt;
  logic [WAY_COUNT-1:0] vrow_nxt;
  outcome_t             outcome;
  way_t                 used;

  logic [COUNT_W-1:0]   hits_r, misses_r, evicts_r;
  logic [COUNT_W-1:0]   hits_nxt, misses_nxt, evicts_nxt;

  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic [COUNT_W-1:0]   out_hits_r, out_misses_r, out_evicts_r;

  // address split
  assign addr_m   = in_address & ADDR_MASK;
  assign tag_full = addr_m >> (SET_FIELD_W + OFFSET_BITS);
  assign set_in   = SET_IDX_W'((addr_m >> OFFSET_BITS) & SET_MASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= PLC_FIFO;
    end else if (cfg_we) begin
      policy_r <= policy_t'(cfg_replace_policy);
    end
  end

  // row memory, read data registered
  always_ff @(posedge clk) begin
    if (cmd.commit) mem[set_r[SET_FIELD_W > 0 ? SET_FIELD_W-1 : 0 : 0]] <= row_nxt;
    if (cmd.load) begin
      row_r <= mem[set_in[SET_FIELD_W > 0 ? SET_FIELD_W-1 : 0 : 0]];
      tag_r <= tag_full[TAG_FIELD_W-1:0];
      set_r <= set_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SET_ROWS; s++) valid_r[s] <= '0;
      vrow_r <= '0;
    end else begin
      if (cmd.commit) valid_r[set_r[SET_FIELD_W > 0 ? SET_FIELD_W-1 : 0 : 0]] <= vrow_nxt;
      if (cmd.load) vrow_r <= valid_r[set_in[SET_FIELD_W > 0 ? SET_FIELD_W-1 : 0 : 0]];
    end
  end

  // way compare and rank update
  always_comb begin
    logic [CNT_W-1:0] vcnt;
    logic             hit, found_free, found_old;
    way_t             hit_way, free_way, old_way, r;
    vcnt       = '0;
    hit        = 1'b0;
    found_free = 1'b0;
    found_old  = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    old_way    = '0;
    row_nxt    = row_r;
    vrow_nxt   = vrow_r;
    for (int w = 0; w < WAY_COUNT; w++) begin
      vcnt = vcnt + CNT_W'(vrow_r[w]);
      if (!hit && vrow_r[w] && row_r.tags[w] == tag_r) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!found_free && !vrow_r[w]) begin
        found_free = 1'b1;
        free_way   = WAY_W'(w);
      end
      if (!found_old && row_r.ranks[w] == '0) begin
        found_old = 1'b1;
        old_way   = WAY_W'(w);
      end
    end
    r = row_r.ranks[hit_way];
    if (hit) begin
      outcome = OUT_HIT;
      used    = hit_way;
      if (policy_r == PLC_LRU) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (vrow_r[w] && row_r.ranks[w] > r) row_nxt.ranks[w] = row_r.ranks[w] - WAY_W'(1);
        end
        row_nxt.ranks[hit_way] = WAY_W'(vcnt - CNT_W'(1));
      end
    end else if (found_free) begin
      outcome                 = OUT_FILL;
      used                    = free_way;
      vrow_nxt[free_way]      = 1'b1;
      row_nxt.tags[free_way]  = tag_r;
      row_nxt.ranks[free_way] = WAY_W'(vcnt);
    end else begin
      outcome = OUT_EVICT;
      used    = old_way;
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (WAY_W'(w) != old_way && row_r.ranks[w] != '0) begin
          row_nxt.ranks[w] = row_r.ranks[w] - WAY_W'(1);
        end
      end
      row_nxt.tags[old_way]  = tag_r;
      row_nxt.ranks[old_way] = WAY_W'(WAY_COUNT - 1);
    end
  end

  assign hits_nxt   = (outcome == OUT_HIT)   ? sat_inc(hits_r)   : hits_r;
  assign misses_nxt = (outcome != OUT_HIT)   ? sat_inc(misses_r) : misses_r;
  assign evicts_nxt = (outcome == OUT_EVICT) ? sat_inc(evicts_r) : evicts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (cmd.commit) begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  // result register: holds a beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome_r <= outcome;
      out_way_r     <= WAY_OUT_W'(used);
      out_hits_r    <= hits_nxt;
      out_misses_r  <= misses_nxt;
      out_evicts_r  <= evicts_nxt;
    end
  end

  assign sts.slot_busy       = out_valid_r && out_stall;
  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_way_used        = out_way_r;
  assign out_hits_total      = out_hits_r;
  assign out_misses_total    = out_misses_r;
  assign out_evictions_total = out_evicts_r;

endmodule

>>> rtl/set_assoc_cache_lookup.sv
// top level of the set-associative cache lookup
// An access beat on the in_ channel carries a byte address. The block splits it into
// offset, set and tag, compares the tag with the valid ways of the set and returns one
// result beat on the out_ channel: hit, fill of a free way or eviction, the way used
// and saturating hit, miss and eviction counts that include this access.
// cfg_we writes cfg_replace_policy (0 fifo, 1 lru); write it only while no access is
// in flight.
// An accepted access reads its set row from the tag memory at the accept edge and
// resolves in the resolve state, which writes the row back and loads the result
// register; in_stall stays high in resolve, so a new access is taken only after
// the current one commits.
// The result register lets the next access be accepted while a beat waits; if the
// receiver keeps stalling, the following access waits in resolve and in_stall stays
// high until the register frees.
// Reset clears all valid bits, the counters, the policy (fifo) and the channels at
// once; no clearing pass is needed.
module set_assoc_cache_lookup import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_ADDR_W-1:0] in_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUTCOME_W-1:0] out_outcome,
  output logic [WAY_OUT_W-1:0] out_way_used,
  output logic [COUNT_W-1:0]   out_hits_total,
  output logic [COUNT_W-1:0]   out_misses_total,
  output logic [COUNT_W-1:0]   out_evictions_total,
  input  logic                 cfg_we,
  input  logic                 cfg_replace_policy
);

  sacl_cmd_t cmd;
  sacl_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_address          (in_address),
    .cfg_we              (cfg_we),
    .cfg_replace_policy  (cfg_replace_policy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_outcome         (out_outcome),
    .out_way_used        (out_way_used),
    .out_hits_total      (out_hits_total),
    .out_misses_total    (out_misses_total),
    .out_evictions_total (out_evictions_total)
  );

endmodule

>>> test/tb_set_assoc_cache_lookup.sv
// testbench for the set-associative cache lookup: predicted outcome, way and counts per access
`timescale 1ns / 100ps

import sacl_pkg::*;

typedef struct packed {
  outcome_t               outcome;
  logic [WAY_OUT_W-1:0]   way;
  logic [COUNT_W-1:0]     hits;
  logic [COUNT_W-1:0]     misses;
  logic [COUNT_W-1:0]     evicts;
} lookup_result_t;

class lookup_tracker;
  policy_t            policy;
  bit                 line_ok [SET_ROWS][WAY_COUNT];
  tag_t               line_tags [SET_ROWS][WAY_COUNT];
  int                 age [SET_ROWS][WAY_COUNT];
  logic [COUNT_W-1:0] hits, misses, evicts;
  lookup_result_t     expected_lookups [$];
  int                 errors;

  function new();
    policy = PLC_FIFO;
    foreach (line_ok[s, w]) begin
      line_ok[s][w] = 1'b0;
      line_tags[s][w] = '0;
      age[s][w] = 0;
    end
    hits = '0;
    misses = '0;
    evicts = '0;
    errors = 0;
  endfunction

  function int pending();
    return expected_lookups.size();
  endfunction

  // work out what the block returns for an accepted access and update the shadow cache
  function void note_access(logic [IN_ADDR_W-1:0] addr);
    int             row, used, filled, r;
    bit             hit, free_found, oldest_found;
    tag_t           tag;
    lookup_result_t res;
    row = int'(addr[OFFSET_BITS +: SET_FIELD_W]);
    tag = tag_t'(addr >> (OFFSET_BITS + SET_FIELD_W));
    filled = 0;
    used = 0;
    hit = 1'b0;
    free_found = 1'b0;
    oldest_found = 1'b0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (line_ok[row][w]) filled++;
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!hit && line_ok[row][w] && line_tags[row][w] == tag) begin
        hit = 1'b1;
        used = w;
      end
    end
    if (hit) begin
      hits = (&hits) ? hits : hits + 1'b1;
      res.outcome = OUT_HIT;
      // fifo leaves the ranks alone on a hit
      if (policy == PLC_LRU) begin
        r = age[row][used];
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (line_ok[row][w] && age[row][w] > r) age[row][w]--;
        end
        age[row][used] = filled - 1;
      end
    end else begin
      misses = (&misses) ? misses : misses + 1'b1;
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (!free_found && !line_ok[row][w]) begin
          free_found = 1'b1;
          used = w;
        end
      end
      if (free_found) begin
        res.outcome = OUT_FILL;
        line_ok[row][used] = 1'b1;
        line_tags[row][used] = tag;
        age[row][used] = filled;
      end else begin
        res.outcome = OUT_EVICT;
        evicts = (&evicts) ? evicts : evicts + 1'b1;
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (!oldest_found && age[row][w] == 0) begin
            oldest_found = 1'b1;
            used = w;
          end
        end
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (w != used && age[row][w] > 0) age[row][w]--;
        end
        line_tags[row][used] = tag;
        age[row][used] = WAY_COUNT - 1;
      end
    end
    res.way = WAY_OUT_W'(used);
    res.hits = hits;
    res.misses = misses;
    res.evicts = evicts;
    expected_lookups.push_back(res);
  endfunction

  function int field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function void check_result(lookup_result_t got);
    lookup_result_t want;
    if (expected_lookups.size() == 0) begin
      $display("%0t: result beat with nothing expected, outcome %0d way %0d",
               $time, got.outcome, got.way);
      errors++;
      return;
    end
    want = expected_lookups.pop_front();
    errors += field_differs("outcome", want.outcome, got.outcome);
    errors += field_differs("way_used", want.way, got.way);
    errors += field_differs("hits_total", want.hits, got.hits);
    errors += field_differs("misses_total", want.misses, got.misses);
    errors += field_differs("evictions_total", want.evicts, got.evicts);
  endfunction
endclass

module tb_set_assoc_cache_lookup;

  localparam int STUCK_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 80;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [IN_ADDR_W-1:0] in_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [WAY_OUT_W-1:0] out_way_used;
  logic [COUNT_W-1:0]   out_hits_total;
  logic [COUNT_W-1:0]   out_misses_total;
  logic [COUNT_W-1:0]   out_evictions_total;
  logic                 cfg_we = 1'b0;
  logic                 cfg_replace_policy = 1'b0;

  lookup_tracker book = new();
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            stuck = 0;
  tag_t          tag_pool [6];

  set_assoc_cache_lookup dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_outcome         (out_outcome),
    .out_way_used        (out_way_used),
    .out_hits_total      (out_hits_total),
    .out_misses_total    (out_misses_total),
    .out_evictions_total (out_evictions_total),
    .cfg_we              (cfg_we),
    .cfg_replace_policy  (cfg_replace_policy)
  );

  always #10 clk = ~clk;

  // result side: check each accepted beat, then decide the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_result({outcome_t'(out_outcome), out_way_used, out_hits_total,
                         out_misses_total, out_evictions_total});
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
  end

  initial begin
    while (stuck < STUCK_LIMIT) @(posedge clk);
    $display("set_assoc_cache_lookup: mismatch");
    $finish;
  end

  function automatic logic [IN_ADDR_W-1:0] make_addr(tag_t t, int row, int off);
    return {t, SET_FIELD_W'(row), OFFSET_BITS'(off)};
  endfunction

  function automatic logic [IN_ADDR_W-1:0] pick_address();
    if ($urandom_range(99) < 8) return {$urandom, $urandom};
    return make_addr(tag_pool[$urandom_range(5)], $urandom_range(SET_ROWS - 1),
                     $urandom_range(LINE_BYTES - 1));
  endfunction

  task automatic drive_access(input logic [IN_ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    book.note_access(addr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // only written once the block has nothing in flight
  task automatic set_policy(input policy_t p);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_replace_policy <= p;
    @(posedge clk);
    book.policy = p;
    cfg_we <= 1'b0;
  endtask

  // fill one set, hit twice, then force evictions so fifo and lru part ways
  task automatic directed_pass(input int row);
    drive_access('0);
    drive_access('1);
    drive_access(make_addr('0, row, 0));
    drive_access(make_addr('1, row, 15));
    drive_access(make_addr(tag_t'(56'h5A_A5F0_0FC3_3C96), row, 7));
    drive_access(make_addr(tag_t'(1), row, 8));
    drive_access(make_addr('0, row, 3));
    drive_access(make_addr(tag_t'(1), row, 0));
    drive_access(make_addr(tag_t'(2), row, 1));
    drive_access(make_addr('1, row, 2));
    drive_access(make_addr('0, row, 0));
  endtask

  initial begin
    int m;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = tag_t'({$urandom, $urandom});
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_policy(PLC_FIFO);
    directed_pass(5);
    set_policy(PLC_LRU);
    directed_pass(9);

    for (int ph = 0; ph < 8; ph++) begin
      set_policy(policy_t'(ph % 2));
      m = ph / 2;
      send_idle_pct = (m == 1) ? 80 : (m == 3) ? 31 : 0;
      recv_stall_pct = (m == 2) ? 80 : (m == 3) ? 31 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain();
        drive_access(pick_address());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("set_assoc_cache_lookup: match");
    end else begin
      $display("set_assoc_cache_lookup: mismatch");
    end
    $finish;
  end

endmodule
